// ===== sv/assert_macros.svh =====
// assertion macros shared by the pwm channel register block
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication under an active-low reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// next-cycle implication under an active-low reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/pcr_pkg.sv =====
// package for the pwm channel counter register block
// holds widths, register offsets, channel state type, fsm states and the decode helper
package pcr_pkg;

  localparam int DEF_NUM_CHANNELS = 12;
  localparam int REGS_PER_CH      = 5;
  localparam int CH_STRIDE        = 20;   // 0x14 bytes per channel

  localparam int OFF_W    = 8;
  localparam int SIZE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 16;
  localparam int MOD_W    = CNT_W + 1;
  localparam int STEP_W   = 5;
  localparam int CHOFF_W  = 5;
  localparam int DEC_CH_W = 4;
  localparam int IN_TDATA_W = 48;

  // offsets inside one channel
  localparam logic [CHOFF_W-1:0] OFF_CSR = 5'h00;
  localparam logic [CHOFF_W-1:0] OFF_CTR = 5'h08;
  localparam logic [CHOFF_W-1:0] OFF_TOP = 5'h10;

  localparam logic [CNT_W-1:0] CTR_STEP   = 16'd17;
  localparam logic [CNT_W-1:0] WRAP_RESET = 16'hFFFF;

  // access kinds and sizes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;

  typedef struct packed {
    logic             enable;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] wrap;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{enable: 1'b0, count: '0, wrap: WRAP_RESET};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LOOK,
    ST_DIV,
    ST_DONE
  } pcr_state_t;

  // channel number of a byte offset: off / 20 as off * 205 >> 12, exact for 8-bit offsets
  function automatic logic [DEC_CH_W-1:0] chan_of(input logic [OFF_W-1:0] off);
    logic [15:0] prod;
    prod = 16'(off) * 16'd205;
    return prod[15:12];
  endfunction

endpackage

// ===== sv/pcr_word_mem.sv =====
// register word store: one write port, one registered read port
// valid bits make unwritten words read as zero after reset; uses pcr_pkg
module pcr_word_mem #(
  parameter int DEPTH  = 60,
  parameter int ADDR_W = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [pcr_pkg::DATA_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [pcr_pkg::DATA_W-1:0] wr_data
);
  import pcr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] data_r;
  logic              vld_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  // written-entry flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = vld_r ? data_r : '0;

endmodule

// ===== sv/pcr_chan_mem.sv =====
// per-channel state store (enable, counter, wrap) with registered read
// entries never written read as the reset state; uses pcr_pkg
module pcr_chan_mem #(
  parameter int DEPTH  = 12,
  parameter int ADDR_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output pcr_pkg::chan_state_t rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  pcr_pkg::chan_state_t wr_data
);
  import pcr_pkg::*;

  chan_state_t      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  chan_state_t      data_r;
  logic             vld_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  // written-entry flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = vld_r ? data_r : CHAN_RESET;

endmodule

// ===== sv/pcr_mod_unit.sv =====
// iterative remainder unit: num mod den, one quotient bit per cycle
// restoring scheme over MOD_W bits; uses pcr_pkg
module pcr_mod_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pcr_pkg::MOD_W-1:0] num,
  input  logic [pcr_pkg::MOD_W-1:0] den,
  output logic                      done,
  output logic [pcr_pkg::CNT_W-1:0] rem
);
  import pcr_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic [MOD_W-1:0]  num_r;
  logic [MOD_W-1:0]  den_r;
  logic [MOD_W-1:0]  rem_r;
  logic [MOD_W:0]    shifted;
  logic [MOD_W:0]    diff;
  logic              ge;

  // one restoring step
  assign shifted = {rem_r, num_r[MOD_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_W'(MOD_W);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // datapath needs no reset
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      num_r <= {num_r[MOD_W-2:0], 1'b0};
      rem_r <= ge ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
    end
  end

  // remainder stays below den, so it fits the counter width
  assign done = busy_r && (cnt_r == '0);
  assign rem  = rem_r[CNT_W-1:0];

endmodule

// ===== sv/pwm_channel_counter_registers_core.sv =====
// Register window of NUM_CHANNELS pwm channels, five words per channel at a 20-byte stride.
// Input channel (in_*): one register access per transaction. in_tuser is the access kind
// (0 read, 1 write); in_tdata carries byte offset, access size and write data.
// Output channel (out_*): exactly one result word per access, zero for writes.
// Writes merge byte, halfword or word data into the word store; a write at a channel's
// CSR offset sets its enable flag (enabling clears the counter), a write at TOP loads the
// wrap value. A read of CTR on an enabled channel advances the counter by 17 modulo
// wrap + 1 and returns it; other reads return the stored word; offsets past the window
// read zero and ignore writes.
// An accepted access reads both memories in RD and is decoded in LOOK, where writes are stored;
// a counter read then waits in DIV for the bit-serial remainder unit and stores the new count
// there. DONE loads the output register, and no new access is taken before DONE is left. This
// single read-modify-write pass through the two state memories sets the pace of the block.
// Reset clears all channels to disabled, counter zero, wrap 0xFFFF and words zero at once;
// the block accepts accesses in the first cycle after reset.
// A stalled receiver holds the result in the output register; one more access can be taken
// and processed meanwhile, and its result waits until the output register is free.
`include "assert_macros.svh"

module pwm_channel_counter_registers_core #(
  parameter int NUM_CHANNELS = pcr_pkg::DEF_NUM_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fields from bit 0: byte_offset[7:0], access_bytes[10:8], write_data[42:11], zero fill
  input  logic [pcr_pkg::IN_TDATA_W-1:0] in_tdata,
  // fields from bit 0: func
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fields from bit 0: read_data[31:0]
  output logic [pcr_pkg::DATA_W-1:0]     out_tdata
);
  import pcr_pkg::*;

  localparam int NUM_WORDS = NUM_CHANNELS * REGS_PER_CH;
  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int WORD_W    = $clog2(NUM_WORDS);
  localparam logic [OFF_W:0] WINDOW_BYTES = (OFF_W + 1)'(NUM_CHANNELS * CH_STRIDE);

  // input field split
  logic [OFF_W-1:0]  in_off;
  logic [SIZE_W-1:0] in_size;
  logic [DATA_W-1:0] in_data;
  assign in_off  = in_tdata[OFF_W-1:0];
  assign in_size = in_tdata[OFF_W+SIZE_W-1:OFF_W];
  assign in_data = in_tdata[OFF_W+SIZE_W+DATA_W-1:OFF_W+SIZE_W];

  // address decode at acceptance
  logic [DEC_CH_W-1:0] dec_ch;
  logic [OFF_W-1:0]    dec_choff;
  logic                dec_oow;
  assign dec_ch    = chan_of(in_off);
  assign dec_choff = in_off - OFF_W'({4'd0, dec_ch} * 8'd20);
  assign dec_oow   = {1'b0, in_off} >= WINDOW_BYTES;

  // held access
  logic                req_write_r;
  logic                req_oow_r;
  logic [CH_W-1:0]     req_ch_r;
  logic [WORD_W-1:0]   req_word_r;
  logic [CHOFF_W-1:0]  req_choff_r;
  logic [1:0]          req_lane_r;
  logic [SIZE_W-1:0]   req_size_r;
  logic [DATA_W-1:0]   req_data_r;

  pcr_state_t        state_r, state_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic              accept, out_load;

  // memory ports
  logic              mem_rd_en;
  logic              word_wr_en;
  logic [DATA_W-1:0] word_rd, word_wr;
  logic              chan_wr_en;
  chan_state_t       chan_rd, chan_wr;

  // remainder unit
  logic              mod_start, mod_done;
  logic [MOD_W-1:0]  mod_num, mod_den;
  logic [CNT_W-1:0]  mod_rem;

  assign accept = in_tvalid && in_tready;

  pcr_word_mem #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (WORD_W)
  ) u_word_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (req_word_r),
    .rd_data (word_rd),
    .wr_en   (word_wr_en),
    .wr_addr (req_word_r),
    .wr_data (word_wr)
  );

  pcr_chan_mem #(
    .DEPTH  (NUM_CHANNELS),
    .ADDR_W (CH_W)
  ) u_chan_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (req_ch_r),
    .rd_data (chan_rd),
    .wr_en   (chan_wr_en),
    .wr_addr (req_ch_r),
    .wr_data (chan_wr)
  );

  assign mod_num = {1'b0, chan_rd.count} + {1'b0, CTR_STEP};
  assign mod_den = {1'b0, chan_rd.wrap} + 1'b1;

  pcr_mod_unit u_mod_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (mod_num),
    .den   (mod_den),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // byte-lane merge of write data into the old word
  logic [3:0]        byte_en;
  logic [DATA_W-1:0] wr_repl;
  logic [DATA_W-1:0] merged;
  always_comb begin
    priority if (req_size_r == SIZE_BYTE) begin
      byte_en = 4'b0001 << req_lane_r;
      wr_repl = {4{req_data_r[7:0]}};
    end else if (req_size_r == SIZE_HALF) begin
      byte_en = req_lane_r[1] ? 4'b1100 : 4'b0011;
      wr_repl = {2{req_data_r[15:0]}};
    end else begin
      byte_en = 4'b1111;
      wr_repl = req_data_r;
    end
    for (int b = 0; b < 4; b++) begin
      merged[b*8 +: 8] = byte_en[b] ? wr_repl[b*8 +: 8] : word_rd[b*8 +: 8];
    end
  end

  // sequencer: next state, memory controls and result
  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    in_tready  = 1'b0;
    mem_rd_en  = 1'b0;
    word_wr_en = 1'b0;
    word_wr    = merged;
    chan_wr_en = 1'b0;
    chan_wr    = chan_rd;
    mod_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_DONE;
        res_nxt   = '0;
        if (req_oow_r) begin
          res_nxt = '0;
        end else if (req_write_r == FUNC_WRITE) begin
          word_wr_en = 1'b1;
          if (req_choff_r == OFF_CSR) begin
            chan_wr_en     = 1'b1;
            chan_wr.enable = req_data_r[0];
            if (req_data_r[0]) begin
              chan_wr.count = '0;
            end
          end else if (req_choff_r == OFF_TOP) begin
            chan_wr_en   = 1'b1;
            chan_wr.wrap = req_data_r[CNT_W-1:0];
          end
        end else if (req_choff_r == OFF_CTR && chan_rd.enable) begin
          mod_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          res_nxt = word_rd;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          chan_wr_en    = 1'b1;
          chan_wr.count = mod_rem;
          res_nxt       = {{(DATA_W-CNT_W){1'b0}}, mod_rem};
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register keeps the result while the receiver stalls
  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
    if (accept) begin
      req_write_r <= in_tuser;
      req_oow_r   <= dec_oow;
      req_ch_r    <= CH_W'(dec_ch);
      req_word_r  <= WORD_W'(in_off[OFF_W-1:2]);
      req_choff_r <= dec_choff[CHOFF_W-1:0];
      req_lane_r  <= in_off[1:0];
      req_size_r  <= in_size;
      req_data_r  <= in_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `ASSERT_IMPL(a_done_in_div, clk, rst_n, mod_done, state_r == ST_DIV)
  `ASSERT_IMPL(a_rem_below_modulus, clk, rst_n, mod_done, {1'b0, mod_rem} < mod_den)
  `ASSERT_NEXT(a_result_waits, clk, rst_n,
               state_r == ST_DONE && out_valid_r && !out_tready, state_r == ST_DONE)

endmodule

// ===== tb/pwm_channel_counter_registers_core_tb.sv =====
// testbench for the pwm channel counter register window: directed table, then random accesses
// every result is checked against a table value or an in-bench model of the channel state and the word store
// depends on pcr_pkg and pwm_channel_counter_registers_core
module pwm_channel_counter_registers_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcr_pkg::*;

  localparam int NUM_CH       = DEF_NUM_CHANNELS;
  localparam int NUM_WORDS    = NUM_CH * REGS_PER_CH;
  localparam int WINDOW_BYTES = NUM_CH * CH_STRIDE;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int TAIL_CYCLES  = 30;

  typedef struct packed {
    logic              func;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] data;
  } access_t;

  typedef struct {
    access_t           acc;
    bit                known;
    logic [DATA_W-1:0] want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;

  pwm_channel_counter_registers_core #(.NUM_CHANNELS(NUM_CH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // model of the channel state and word store
  logic              chan_on    [NUM_CH];
  logic [CNT_W-1:0]  chan_count [NUM_CH];
  logic [CNT_W-1:0]  chan_wrap  [NUM_CH];
  logic [DATA_W-1:0] reg_word   [NUM_WORDS];

  logic [DATA_W-1:0] read_data_q[$];
  table_row_t        directed_rows[$];

  int errors = 0;
  int n_accesses = 0;
  int n_checked = 0;
  int n_ctr_steps = 0;
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  logic [DATA_W-1:0] want_word;

  // one access against the model; returns the read data and updates the state
  function automatic logic [DATA_W-1:0] access_result(input access_t a);
    int unsigned ch, widx, shift, modulus, next;
    logic [CHOFF_W-1:0] ch_off;
    logic [DATA_W-1:0] old;
    if (int'(a.off) >= WINDOW_BYTES) return '0;
    ch     = a.off / CH_STRIDE;
    ch_off = CHOFF_W'(a.off % CH_STRIDE);
    widx   = a.off >> 2;
    if (a.func == FUNC_WRITE) begin
      old = reg_word[widx];
      if (ch_off == OFF_CSR) begin
        chan_on[ch] = a.data[0];
        if (a.data[0]) chan_count[ch] = '0;
      end else if (ch_off == OFF_TOP) begin
        chan_wrap[ch] = a.data[CNT_W-1:0];
      end
      if (a.size == SIZE_BYTE) begin
        shift = (a.off & 3) * 8;
        reg_word[widx] = (old & ~(32'hFF << shift)) | ((a.data & 32'hFF) << shift);
      end else if (a.size == SIZE_HALF) begin
        shift = (a.off & 2) * 8;
        reg_word[widx] = (old & ~(32'hFFFF << shift)) | ((a.data & 32'hFFFF) << shift);
      end else begin
        reg_word[widx] = a.data;
      end
      return '0;
    end
    if (ch_off == OFF_CTR && chan_on[ch]) begin
      modulus = int'(chan_wrap[ch]) + 1;
      next    = int'(chan_count[ch]) + int'(CTR_STEP);
      chan_count[ch] = CNT_W'(next % modulus);
      n_ctr_steps++;
      return DATA_W'(chan_count[ch]);
    end
    return reg_word[widx];
  endfunction

  // offer one access, wait for its transaction, then queue its expected word
  task automatic send_access(input access_t a, input bit known, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= a.func;
    in_tdata  <= {5'b0, a.data, a.size, a.off};
    do @(posedge clk); while (!in_tready);
    predicted = access_result(a);
    read_data_q.push_back(known ? want : predicted);
    n_accesses++;
  endtask

  // stop offering and wait until every expected word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (read_data_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic func, input int off, input int size,
                         input logic [DATA_W-1:0] data, input bit known,
                         input logic [DATA_W-1:0] want);
    table_row_t r;
    r.acc   = '{func: func, off: OFF_W'(off), size: SIZE_W'(size), data: data};
    r.known = known;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  // mostly well-formed channel traffic: enable, set top, read the counter; rest is noise
  function automatic access_t random_access();
    access_t a;
    int unsigned pick, ch;
    pick   = $urandom_range(99);
    ch     = $urandom_range(NUM_CH - 1);
    a.data = $urandom();
    a.size = SIZE_W'($urandom_range(7));
    a.func = FUNC_READ;
    if (pick < 35) begin
      a.off = OFF_W'(ch * CH_STRIDE + int'(OFF_CTR));
    end else if (pick < 50) begin
      a.func    = FUNC_WRITE;
      a.off     = OFF_W'(ch * CH_STRIDE + int'(OFF_CSR));
      a.data[0] = ($urandom_range(3) != 0);
    end else if (pick < 62) begin
      a.func = FUNC_WRITE;
      a.off  = OFF_W'(ch * CH_STRIDE + int'(OFF_TOP));
      if ($urandom_range(1) != 0) a.data[CNT_W-1:0] = CNT_W'($urandom_range(200));
    end else if (pick < 82) begin
      a.off = OFF_W'($urandom_range(255));
    end else begin
      a.func = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
      a.off  = OFF_W'($urandom_range(255));
    end
    return a;
  endfunction

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // compare each result transaction with the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (read_data_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want_word = read_data_q.pop_front();
        n_checked++;
        if (out_tdata !== want_word) begin
          $display("%0t: read_data mismatch, expected %h, actual %h",
                   $time, want_word, out_tdata);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #10ms;
    $display("pwm_channel_counter_registers_core_tb NOT OK");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      chan_on[i]    = 1'b0;
      chan_count[i] = '0;
      chan_wrap[i]  = WRAP_RESET;
    end
    for (int i = 0; i < NUM_WORDS; i++) reg_word[i] = '0;

    // reset values, window edge, enable and counter steps, narrow merges, wrap extremes
    add_row(FUNC_READ,    0, 4, 32'h0,        1, 32'h0);
    add_row(FUNC_READ,    8, 4, 32'h0,        1, 32'h0);
    add_row(FUNC_READ,  240, 4, 32'h0,        1, 32'h0);
    add_row(FUNC_WRITE, 255, 4, 32'hFFFFFFFF, 1, 32'h0);
    add_row(FUNC_READ,  255, 1, 32'hFFFFFFFF, 1, 32'h0);
    add_row(FUNC_WRITE,   0, 4, 32'h1,        1, 32'h0);
    add_row(FUNC_READ,    8, 4, 32'h0,        1, 32'd17);
    add_row(FUNC_READ,    8, 2, 32'h0,        1, 32'd34);
    add_row(FUNC_WRITE,  16, 2, 32'h00000005, 1, 32'h0);
    add_row(FUNC_READ,    8, 4, 32'h0,        0, 32'h0);
    add_row(FUNC_WRITE,  16, 1, 32'hFFFF0000, 1, 32'h0);
    add_row(FUNC_READ,    8, 4, 32'h0,        1, 32'h0);
    add_row(FUNC_WRITE, 236, 4, 32'hFFFFFFFF, 1, 32'h0);
    add_row(FUNC_WRITE, 220, 1, 32'h000000FF, 1, 32'h0);
    add_row(FUNC_READ,  228, 4, 32'h0,        1, 32'd17);
    add_row(FUNC_WRITE,   1, 1, 32'h000000AB, 1, 32'h0);
    add_row(FUNC_WRITE,   6, 2, 32'h1234BEEF, 1, 32'h0);
    add_row(FUNC_READ,    4, 4, 32'h0,        0, 32'h0);
    add_row(FUNC_WRITE,   0, 2, 32'hFFFF0000, 1, 32'h0);
    add_row(FUNC_READ,    8, 4, 32'h0,        0, 32'h0);
    add_row(FUNC_WRITE,   9, 1, 32'h00000077, 1, 32'h0);
    add_row(FUNC_READ,    8, 1, 32'h0,        0, 32'h0);
    add_row(FUNC_WRITE,  40, 0, 32'hA5A55A5A, 1, 32'h0);
    add_row(FUNC_WRITE,  44, 7, 32'h0F0F0F0F, 1, 32'h0);
    add_row(FUNC_READ,   40, 3, 32'h0,        0, 32'h0);
    add_row(FUNC_READ,  239, 4, 32'h0,        0, 32'h0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].known, directed_rows[i].want);
    drain();

    // long receiver hold-off while accesses keep coming, so the input stalls
    hold_req = 1'b1;
    repeat (12) send_access(random_access(), 0, '0);
    drain();

    // random phases: no idling, idle sender, stalling receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 27 : 0;
      sink_stall_pct  = (phase == 2) ? 79 : (phase == 3) ? 27 : 0;
      repeat (ITEMS_PER_PHASE) send_access(random_access(), 0, '0);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d accesses, %0d results checked, %0d counter advances",
             n_accesses, n_checked, n_ctr_steps);
    $display("directed edge cases plus random traffic under four idle/stall mixes and a hold-off");
    if (errors == 0 && read_data_q.size() == 0) begin
      $display("pwm_channel_counter_registers_core_tb OK");
    end else begin
      $display("pwm_channel_counter_registers_core_tb NOT OK");
    end
    $finish;
  end

endmodule
